FILE: design/eai_pkg.sv
// Package for the elite archive insert core: sizes, constants and shared types.
// No dependencies.
package eai_pkg;

  localparam int CellsPerDim = 8;
  localparam int TypeCount = 5;
  localparam int NumCells = CellsPerDim * CellsPerDim;
  localparam int IdxW = $clog2(NumCells);
  localparam int DimW = $clog2(CellsPerDim);
  localparam int CntW = $clog2(NumCells + 1);
  localparam int HalfSpan = (2 * CellsPerDim - 1) * 128;
  localparam int CoordLimit = (CellsPerDim - 1) * 256;
  // Dividend num*HalfSpan: num up to 16 bits, HalfSpan 11 bits.
  localparam int NumW = 16;
  localparam int DvdW = NumW + $clog2(HalfSpan + 1);
  localparam int QW = DvdW;
  localparam int DvsW = 16;
  localparam int StepW = $clog2(DvdW + 1);

  // Fields kept per cell: fitness, identity, sigma, position fractions.
  localparam int EntryW = 32 + 32 + 16 + 16;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIVR  = 6'b000010,
    ST_DIVC  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_DEC   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  localparam logic CMD_TYPE = 1'b0;
  localparam logic CMD_MORPH = 1'b1;

endpackage

FILE: design/eai_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module eai_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write when enabled; the output register reads the addressed word in every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/elite_archive_insert_core.sv
// Elite archive insert core: one restoring divider (one quotient bit a cycle) is used for
// row then column. Each item passes the row division, the column division, the RAM read,
// the decision and the output state; an output stall holds the result and delays the next
// input transfer. One item at a time; in_stall stays high while an item is at work or a
// result waits.
// Synchronous active-high reset clears the valid bits, the fill count, the epsilon and out_valid, and returns to idle.
// Depends on eai_pkg and eai_ram.
module elite_archive_insert_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [39:0] type_counts,
  input  logic [7:0]  total_sensors,
  input  logic [15:0] measure,
  input  logic [15:0] measure_max,
  input  logic signed [31:0] fitness,
  input  logic [15:0] entry_id,
  input  logic [15:0] birth_date,
  input  logic [15:0] mutation_step,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [2:0]  cell_row,
  output logic [2:0]  cell_col,
  output logic        newly_filled,
  output logic [eai_pkg::CntW-1:0] filled_count
);
  import eai_pkg::*;

  state_t state;
  logic [30:0] epsilon;
  logic [NumCells-1:0] valid_bits;
  logic [CntW-1:0] occupied;

  // Captured item.
  logic signed [31:0] fit_q;
  logic [31:0] ident_q;
  logic [15:0] sigma_q;
  logic [15:0] meas_q, meas_max_q;
  logic        row_fixed;
  logic [QW-1:0] rq, cq;

  // Shared divider.
  logic [DvdW-1:0] dvd;
  logic [DvsW:0]   rem;
  logic [DvsW-1:0] dvs;
  logic [StepW-1:0] step;
  logic [DvsW+1:0] trial;

  // Row numerator selection at capture time.
  logic [NumW-1:0] row_num;
  logic [DvsW-1:0] row_den;
  logic [3:0] top;
  always_comb begin
    row_num = '0;
    top = '0;
    for (int i = 0; i < TypeCount; i++) begin
      row_num = row_num + NumW'(type_counts[8*i +: 8]);
      if (type_counts[8*i +: 8] != 8'd0) top = 4'(i + 1);
    end
    row_den = DvsW'(total_sensors);
    if (command == CMD_TYPE) begin
      row_num = NumW'(top);
      row_den = DvsW'(TypeCount);
    end
  end

  assign trial = {rem, dvd[DvdW-1]} - {2'b00, dvs};

  // Saturation of a finished quotient.
  function automatic logic [QW-1:0] sat_q(input logic [QW-1:0] q);
    logic [QW-1:0] r;
    r = q;
    if (q > QW'(CoordLimit)) r = QW'(HalfSpan);
    return r;
  endfunction

  logic [DimW-1:0] row_i, col_i;
  logic [7:0] fr, fc;
  assign row_i = (rq[QW-1:8] > (QW-8)'(CellsPerDim - 1)) ? DimW'(CellsPerDim - 1)
                                                        : rq[8 +: DimW];
  assign col_i = (cq[QW-1:8] > (QW-8)'(CellsPerDim - 1)) ? DimW'(CellsPerDim - 1)
                                                        : cq[8 +: DimW];
  assign fr = rq[7:0];
  assign fc = cq[7:0];
  logic [IdxW-1:0] idx;
  assign idx = {row_i, col_i};

  // Entry store.
  logic ram_we;
  logic [EntryW-1:0] rd, wd;
  assign wd = {fit_q, ident_q, sigma_q, fr, fc};
  eai_ram #(.Width(EntryW), .Depth(NumCells)) u_ram (
    .clk(clk), .we(ram_we), .addr(idx), .wdata(wd), .rdata(rd)
  );

  // Replacement decision.
  logic signed [32:0] diff, mag;
  logic signed [8:0] dr, dc, sdr, sdc;
  logic [17:0] dist_new, dist_old;
  logic take, fresh;
  always_comb begin
    diff = 33'(fit_q) - 33'(signed'(rd[95:64]));
    mag = diff[32] ? -diff : diff;
    dr = $signed({1'b0, fr}) - 9'sd128;
    dc = $signed({1'b0, fc}) - 9'sd128;
    sdr = $signed({1'b0, rd[15:8]}) - 9'sd128;
    sdc = $signed({1'b0, rd[7:0]}) - 9'sd128;
    dist_new = 18'(dr) * 18'(dr) + 18'(dc) * 18'(dc);
    dist_old = 18'(sdr) * 18'(sdr) + 18'(sdc) * 18'(sdc);
    fresh = !valid_bits[idx];
    take = fresh || (diff > $signed(33'(epsilon))) ||
           ((mag <= $signed(33'(epsilon))) && (dist_new < dist_old));
  end
  assign ram_we = (state == ST_DEC) && take;

  assign in_stall = (state != ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      epsilon <= '0;
      valid_bits <= '0;
      occupied <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) epsilon <= cfg_wdata;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            fit_q <= fitness;
            ident_q <= {entry_id, birth_date};
            sigma_q <= mutation_step;
            meas_q <= measure;
            meas_max_q <= measure_max;
            row_fixed <= (command == CMD_TYPE) && (top == 4'd0);
            rq <= QW'(HalfSpan / 2);
            dvd <= DvdW'(row_num) * DvdW'(HalfSpan);
            dvs <= row_den;
            rem <= '0;
            step <= '0;
            state <= ST_DIVR;
          end
        end
        ST_DIVR, ST_DIVC: begin
          if (step == StepW'(DvdW)) begin
            if (state == ST_DIVR) begin
              if (!row_fixed) rq <= (dvs == '0) ? QW'(HalfSpan) : sat_q(dvd);
              dvd <= DvdW'(meas_q) * DvdW'(HalfSpan);
              dvs <= meas_max_q;
              rem <= '0;
              step <= '0;
              state <= ST_DIVC;
            end else begin
              if (meas_q == '0) cq <= '0;
              else cq <= (dvs == '0) ? QW'(HalfSpan) : sat_q(dvd);
              state <= ST_READ;
            end
          end else begin
            if (!trial[DvsW+1]) begin
              rem <= trial[DvsW:0];
              dvd <= {dvd[DvdW-2:0], 1'b1};
            end else begin
              rem <= {rem[DvsW-1:0], dvd[DvdW-1]};
              dvd <= {dvd[DvdW-2:0], 1'b0};
            end
            step <= step + StepW'(1);
          end
        end
        ST_READ: state <= ST_DEC;
        ST_DEC: begin
          accepted <= take;
          newly_filled <= fresh;
          cell_row <= 3'(row_i);
          cell_col <= 3'(col_i);
          filled_count <= occupied + CntW'(fresh);
          if (take) valid_bits[idx] <= 1'b1;
          if (fresh) occupied <= occupied + CntW'(1);
          out_valid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result is shown only in the output state.
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == ST_OUT)) else $error("out_valid out of step");
  // The fill count moves by at most one per insert.
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DEC) |=> $stable(occupied)) else $error("fill count moved");
  // A newly filled cell is always accepted.
  a_fresh_acc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && newly_filled) |-> accepted) else $error("fresh not accepted");
  // No transfer is taken while busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("ready while busy");
`endif

endmodule

FILE: tb/sv/elite_archive_insert_core_test.sv
// Self-checking testbench for elite_archive_insert_core: drives candidates with random gaps,
// predicts each insert outcome with a behavioural archive model and checks every transfer.
// Depends on eai_pkg and the core RTL.
module elite_archive_insert_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import eai_pkg::*;

  typedef struct packed {
    logic        command;
    logic [39:0] type_counts;
    logic [7:0]  total_sensors;
    logic [15:0] measure;
    logic [15:0] measure_max;
    logic [31:0] fitness;
    logic [15:0] entry_id;
    logic [15:0] birth_date;
    logic [15:0] mutation_step;
  } candidate_t;

  typedef struct packed {
    logic            accepted;
    logic [2:0]      cell_row;
    logic [2:0]      cell_col;
    logic            newly_filled;
    logic [CntW-1:0] filled_count;
  } outcome_t;

  localparam int CandW = $bits(candidate_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  candidate_t cur = '0;
  candidate_t next_item;
  logic out_valid;
  logic out_stall = 1'b0;
  outcome_t got;

  candidate_t pending_q[$];
  outcome_t   outcome_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  int hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;

  // Archive shadow used for prediction.
  bit                archive_used[NumCells];
  logic signed [31:0] archive_fit[NumCells];
  logic [15:0]       archive_frac[NumCells];
  int                occupied = 0;
  logic [30:0]       tie_margin = '0;

  always #5 clk = ~clk;

  elite_archive_insert_core i_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .command(cur.command), .type_counts(cur.type_counts),
    .total_sensors(cur.total_sensors), .measure(cur.measure),
    .measure_max(cur.measure_max), .fitness(cur.fitness),
    .entry_id(cur.entry_id), .birth_date(cur.birth_date),
    .mutation_step(cur.mutation_step), .out_valid, .out_stall,
    .accepted(got.accepted), .cell_row(got.cell_row), .cell_col(got.cell_col),
    .newly_filled(got.newly_filled), .filled_count(got.filled_count)
  );

  // Scaled Q.8 coordinate with saturation on a zero divisor or overflow.
  function automatic longint unsigned grid_coord(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return HalfSpan;
    q = (num * HalfSpan) / den;
    return (q > CoordLimit) ? HalfSpan : q;
  endfunction

  function automatic int centre_offset(int fr, int fc);
    return (fr - 128) * (fr - 128) + (fc - 128) * (fc - 128);
  endfunction

  // Works out the outcome of one insert and updates the shadow archive.
  function automatic outcome_t predict_insert(candidate_t c);
    outcome_t o;
    longint unsigned rq, cq, total;
    int top, row, col, idx, fr, fc;
    longint diff, mag;
    bit take;
    total = 0;
    top = 0;
    for (int i = 0; i < TypeCount; i++) begin
      total += c.type_counts[8*i +: 8];
      if (c.type_counts[8*i +: 8] != 0) top = i + 1;
    end
    if (c.command == CMD_TYPE) begin
      rq = (top == 0) ? HalfSpan / 2 : grid_coord(top, TypeCount);
    end else begin
      rq = grid_coord(total, c.total_sensors);
    end
    cq = (c.measure == 0) ? 0 : grid_coord(c.measure, c.measure_max);
    row = int'(rq >> 8);
    col = int'(cq >> 8);
    if (row > CellsPerDim - 1) row = CellsPerDim - 1;
    if (col > CellsPerDim - 1) col = CellsPerDim - 1;
    fr = int'(rq & 8'hFF);
    fc = int'(cq & 8'hFF);
    idx = row * CellsPerDim + col;
    o = '0;
    if (!archive_used[idx]) begin
      take = 1'b1;
      o.newly_filled = 1'b1;
      occupied++;
    end else begin
      diff = longint'($signed(c.fitness)) - longint'(archive_fit[idx]);
      mag = diff < 0 ? -diff : diff;
      take = (diff > longint'(tie_margin)) ||
             (mag <= longint'(tie_margin) &&
              centre_offset(fr, fc) < centre_offset(archive_frac[idx][15:8],
                                                    archive_frac[idx][7:0]));
    end
    if (take) begin
      archive_used[idx] = 1'b1;
      archive_fit[idx] = c.fitness;
      archive_frac[idx] = {fr[7:0], fc[7:0]};
    end
    o.accepted = take;
    o.cell_row = 3'(row);
    o.cell_col = 3'(col);
    o.filled_count = CntW'(occupied);
    return o;
  endfunction

  // Driver: presents queued candidates, with random gaps between transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (send_gap > 0 && !quiet) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        next_item = pending_q.pop_front();
        cur <= next_item;
        outcome_q.push_back(predict_insert(next_item));
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and drives receiver stalls.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          outcome_t e;
          e = outcome_q.pop_front();
          if (got.accepted !== e.accepted)
            $display("%0t: accepted exp %0d got %0d", $time, e.accepted, got.accepted);
          if (got.cell_row !== e.cell_row)
            $display("%0t: cell_row exp %0d got %0d", $time, e.cell_row, got.cell_row);
          if (got.cell_col !== e.cell_col)
            $display("%0t: cell_col exp %0d got %0d", $time, e.cell_col, got.cell_col);
          if (got.newly_filled !== e.newly_filled)
            $display("%0t: newly_filled exp %0d got %0d", $time, e.newly_filled,
                     got.newly_filled);
          if (got.filled_count !== e.filled_count)
            $display("%0t: filled_count exp %0d got %0d", $time, e.filled_count,
                     got.filled_count);
          if (got !== e) errors++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0 && !quiet) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 11);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic candidate_t random_candidate();
    candidate_t c;
    c = CandW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 3))
      0: c.type_counts = '0;
      1: c.type_counts = {8'($urandom_range(0, 255)), 32'h0} >> (8 * $urandom_range(0, 4));
      2: c.type_counts = {5{8'($urandom_range(0, 12))}};
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) c.total_sensors = 8'($urandom_range(0, 60));
    if ($urandom_range(0, 1)) c.measure_max = 16'(c.measure + $urandom_range(0, 2000));
    if ($urandom_range(0, 9) == 0) c.measure = '0;
    if ($urandom_range(0, 9) == 0) c.measure_max = '0;
    // Narrow fitness spread makes ties and replacements frequent.
    if ($urandom_range(0, 2) != 0) c.fitness = $signed($urandom_range(0, 4000)) - 2000;
    return c;
  endfunction

  task automatic drain_and_idle();
    wait (pending_q.size() == 0 && outcome_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_margin(logic [30:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tie_margin = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    candidate_t c;
    logic [30:0] margins[4] = '{31'h0, 31'h7FFF_FFFF, 31'd500, 31'd10};
    for (int i = 0; i < NumCells; i++) archive_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, both commands, zero divisors, saturation, top bytes ignored.
    c = '0;
    pending_q.push_back(c);
    c.command = CMD_MORPH;
    pending_q.push_back(c);
    c.type_counts = 40'hFF_FFFF_FFFF; c.total_sensors = 8'hFF; c.measure = 16'hFFFF;
    c.measure_max = 16'hFFFF; c.fitness = 32'h7FFF_FFFF; c.entry_id = 16'hFFFF;
    c.birth_date = 16'hFFFF; c.mutation_step = 16'hFFFF;
    pending_q.push_back(c);
    c.command = CMD_TYPE;
    pending_q.push_back(c);
    c.fitness = 32'h8000_0000; c.measure_max = '0;
    pending_q.push_back(c);
    c.type_counts = 40'hFF_0000_0000; c.measure = 16'd5; c.measure_max = 16'd1;
    pending_q.push_back(c);
    c.command = CMD_MORPH; c.total_sensors = '0; c.type_counts = 40'h1;
    pending_q.push_back(c);
    c.total_sensors = 8'd1; c.type_counts = 40'h02_0000_0000;
    pending_q.push_back(c);
    for (int t = 0; t < TypeCount; t++) begin
      c = '0; c.type_counts[8*t +: 8] = 8'd1; c.measure = 16'd100; c.measure_max = 16'd800;
      c.fitness = t;
      pending_q.push_back(c);
    end
    drain_and_idle();
    // Long receiver hold-off so the core backs up.
    hold_off = 400;
    for (int i = 0; i < 20; i++) pending_q.push_back(random_candidate());
    drain_and_idle();
    // Random phases across tie margin settings; the sender pauses between them.
    foreach (margins[m]) begin
      write_margin(margins[m]);
      for (int i = 0; i < 420; i++) pending_q.push_back(random_candidate());
      drain_and_idle();
    end
    quiet = 1'b1;
    for (int i = 0; i < 150; i++) pending_q.push_back(random_candidate());
    drain_and_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
